/* hw/rtl/fcdm_pkg.sv */
// Shared types and constants for the framed command drive mixer.
package fcdm_pkg;

  // Framing bytes
  localparam logic [7:0] START_BYTE = 8'hFF;
  localparam logic [7:0] STOP_BYTE  = 8'hFE;

  // Configuration register indexes
  localparam logic [7:0] CFG_FORWARD_CENTER = 8'd0;
  localparam logic [7:0] CFG_TURN_CENTER    = 8'd1;

  // Reset values of the centre registers
  localparam logic [7:0] FORWARD_CENTER_RST = 8'd127;
  localparam logic [7:0] TURN_CENTER_RST    = 8'd125;

  // abs*10000/126 == floor(abs*5000/63) == (abs*MAG_MUL) >> MAG_SHIFT, exact for abs <= 510
  localparam int          MAG_SHIFT = 20;
  localparam logic [26:0] MAG_MUL   = 27'd83220318;

  // Frame position while assembling
  typedef enum logic [2:0] {
    POS_HUNT = 3'd0,
    POS_D1   = 3'd1,
    POS_D2   = 3'd2,
    POS_D3   = 3'd3,
    POS_D4   = 3'd4,
    POS_STOP = 3'd5
  } pos_t;

  // Data bytes of one complete frame
  typedef struct packed {
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [7:0] b4;
  } frame_t;

  // Queue status toward both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // One drive result
  typedef struct packed {
    logic [15:0] left_compare;
    logic [15:0] right_compare;
    logic        left_forward;
    logic        right_forward;
    logic [7:0]  aux_byte_three;
    logic [7:0]  aux_byte_four;
  } result_t;

endpackage

/* hw/rtl/fcdm_frame_front.sv */
// Front end: tracks frame position, holds data bytes, pushes complete frames.
module fcdm_frame_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        rx_byte,
  output logic              push,
  output fcdm_pkg::frame_t  frame
);

  fcdm_pkg::pos_t pos_r, pos_nxt;
  logic [7:0] b1_r, b2_r, b3_r, b4_r;
  logic       ld1, ld2, ld3, ld4;

  // Next position
  always_comb begin
    pos_nxt = pos_r;
    if (accept) begin
      case (pos_r)
        fcdm_pkg::POS_D1: pos_nxt = fcdm_pkg::POS_D2;
        fcdm_pkg::POS_D2: pos_nxt = fcdm_pkg::POS_D3;
        fcdm_pkg::POS_D3: pos_nxt = fcdm_pkg::POS_D4;
        fcdm_pkg::POS_D4: pos_nxt = fcdm_pkg::POS_STOP;
        default:          pos_nxt = fcdm_pkg::POS_HUNT;
      endcase
      // start byte restarts the frame from any position
      if (rx_byte == fcdm_pkg::START_BYTE) begin
        pos_nxt = fcdm_pkg::POS_D1;
      end
    end
  end

  // Decode loads and frame push
  always_comb begin
    ld1  = 1'b0;
    ld2  = 1'b0;
    ld3  = 1'b0;
    ld4  = 1'b0;
    push = 1'b0;
    case (pos_r)
      fcdm_pkg::POS_D1:   ld1  = accept;
      fcdm_pkg::POS_D2:   ld2  = accept;
      fcdm_pkg::POS_D3:   ld3  = accept;
      fcdm_pkg::POS_D4:   ld4  = accept;
      fcdm_pkg::POS_STOP: push = accept && (rx_byte == fcdm_pkg::STOP_BYTE);
      default: ;
    endcase
  end

  // Hold position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= fcdm_pkg::POS_HUNT;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  // Capture data bytes
  always_ff @(posedge clk) begin
    if (ld1) b1_r <= rx_byte;
    if (ld2) b2_r <= rx_byte;
    if (ld3) b3_r <= rx_byte;
    if (ld4) b4_r <= rx_byte;
  end

  assign frame = '{b1: b1_r, b2: b2_r, b3: b3_r, b4: b4_r};

endmodule

/* hw/rtl/fcdm_queue.sv */
// Small register queue of complete frames between front and back.
module fcdm_queue #(
  parameter int DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  fcdm_pkg::frame_t     wr_data,
  input  logic                 pop,
  output fcdm_pkg::frame_t     rd_data,
  output fcdm_pkg::q_status_t  status
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  fcdm_pkg::frame_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign status.full  = (count_r == CW'(DEPTH));
  assign status.empty = (count_r == '0);
  assign do_push = push && !status.full;
  assign do_pop  = pop && !status.empty;
  assign rd_data = mem_r[rd_ptr_r];

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wr_data;
  end

endmodule

/* hw/rtl/fcdm_mix_back.sv */
// Back end: mixes forward and turn, scales magnitudes, drives the result register.
module fcdm_mix_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  fcdm_pkg::frame_t   q_frame,
  output logic               q_pop,
  input  logic [7:0]         forward_center,
  input  logic [7:0]         turn_center,
  output logic               res_valid,
  input  logic               res_ready,
  output fcdm_pkg::result_t  res
);

  logic signed [10:0] fwd, trn, left, right;
  logic [8:0]  abs_l, abs_r;

  logic        s1_v_r;
  logic [8:0]  s1_abs_l_r, s1_abs_r_r;
  logic        s1_fwd_l_r, s1_fwd_r_r;
  logic [7:0]  s1_b3_r, s1_b4_r;

  logic [35:0] prod_l, prod_r;
  logic        out_v_r;
  fcdm_pkg::result_t res_r;
  logic        adv_out, s1_load;

  // Mix around centres and take magnitudes
  always_comb begin
    fwd   = $signed({3'b000, q_frame.b1}) - $signed({3'b000, forward_center});
    trn   = $signed({3'b000, q_frame.b2}) - $signed({3'b000, turn_center});
    left  = fwd + trn;
    right = fwd - trn;
    abs_l = left[10]  ? 9'(-left)  : left[8:0];
    abs_r = right[10] ? 9'(-right) : right[8:0];
  end

  // Stall control
  assign adv_out = !out_v_r || res_ready;
  assign s1_load = !s1_v_r || adv_out;
  assign q_pop   = q_valid && s1_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_load) s1_v_r <= q_valid;
      if (adv_out) out_v_r <= s1_v_r;
    end
  end

  // Mix stage register
  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_abs_l_r <= abs_l;
      s1_abs_r_r <= abs_r;
      s1_fwd_l_r <= !left[10];
      s1_fwd_r_r <= !right[10];
      s1_b3_r    <= q_frame.b3;
      s1_b4_r    <= q_frame.b4;
    end
  end

  // Scale by reciprocal multiply
  assign prod_l = 36'(s1_abs_l_r) * 36'(fcdm_pkg::MAG_MUL);
  assign prod_r = 36'(s1_abs_r_r) * 36'(fcdm_pkg::MAG_MUL);

  always_ff @(posedge clk) begin
    if (adv_out && s1_v_r) begin
      res_r.left_compare   <= prod_l[fcdm_pkg::MAG_SHIFT +: 16];
      res_r.right_compare  <= prod_r[fcdm_pkg::MAG_SHIFT +: 16];
      res_r.left_forward   <= s1_fwd_l_r;
      res_r.right_forward  <= s1_fwd_r_r;
      res_r.aux_byte_three <= s1_b3_r;
      res_r.aux_byte_four  <= s1_b4_r;
    end
  end

  assign res_valid = out_v_r;
  assign res       = res_r;

endmodule

/* hw/rtl/framed_command_drive_mixer_core.sv */
// A completed frame passes the frame queue, the mix stage register and the result register.
// Throughput: one byte per cycle; in_ready falls only while the frame queue is full,
// which happens when results are not being taken and QUEUE_DEPTH frames are waiting.
// Configuration writes are taken every cycle (cfg_ready is always high).
// Reset (rst_n low, synchronous): frame hunting, queue and pipeline empty,
// forward centre 127, turn centre 125.
module framed_command_drive_mixer_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_left_compare,
  output logic [15:0] out_right_compare,
  output logic        out_left_forward,
  output logic        out_right_forward,
  output logic [7:0]  out_aux_byte_three,
  output logic [7:0]  out_aux_byte_four,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  logic [7:0] forward_center_r, turn_center_r;
  logic                 in_accept, q_push, q_pop;
  fcdm_pkg::frame_t     push_frame, pop_frame;
  fcdm_pkg::q_status_t  q_stat;
  fcdm_pkg::result_t    res;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      forward_center_r <= fcdm_pkg::FORWARD_CENTER_RST;
      turn_center_r    <= fcdm_pkg::TURN_CENTER_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == fcdm_pkg::CFG_FORWARD_CENTER) forward_center_r <= cfg_data;
      if (cfg_index == fcdm_pkg::CFG_TURN_CENTER)    turn_center_r    <= cfg_data;
    end
  end

  assign in_ready  = !q_stat.full;
  assign in_accept = in_valid && in_ready;

  fcdm_frame_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_accept),
    .rx_byte (in_rx_byte),
    .push    (q_push),
    .frame   (push_frame)
  );

  fcdm_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (push_frame),
    .pop     (q_pop),
    .rd_data (pop_frame),
    .status  (q_stat)
  );

  fcdm_mix_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (!q_stat.empty),
    .q_frame        (pop_frame),
    .q_pop          (q_pop),
    .forward_center (forward_center_r),
    .turn_center    (turn_center_r),
    .res_valid      (out_valid),
    .res_ready      (out_ready),
    .res            (res)
  );

  assign out_left_compare   = res.left_compare;
  assign out_right_compare  = res.right_compare;
  assign out_left_forward   = res.left_forward;
  assign out_right_forward  = res.right_forward;
  assign out_aux_byte_three = res.aux_byte_three;
  assign out_aux_byte_four  = res.aux_byte_four;

  // A frame is never pushed into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("frame pushed into full queue");

  // Queue cannot be full and empty at once
  a_status_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue status inconsistent");

  // A reverse drive always has a nonzero magnitude
  a_reverse_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (!out_left_forward || !out_right_forward)) |->
      ((out_left_forward || out_left_compare != 16'd0) &&
       (out_right_forward || out_right_compare != 16'd0)))
    else $error("reverse flag with zero magnitude");

  // Magnitudes stay within the scaled range
  a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_left_compare <= 16'd40476 && out_right_compare <= 16'd40476))
    else $error("compare value out of range");

endmodule
